// ===== src/bpr_pkg.sv =====
// ----------------------------------------------------------------------------
// BMP pixel row decoder package
// Shared types, depth codes and register indexes of the pixel row decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bpr_pkg;

    // Default sizes
    localparam int MAX_WIDTH_DEF       = 4096;
    localparam int MAX_HEIGHT_DEF      = 4096;
    localparam int PALETTE_ENTRIES_DEF = 256;

    // Command queue between front and back
    localparam int CMD_FIFO_DEPTH = 4;
    localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);

    // Register field widths
    localparam int DIM_W   = 13;
    localparam int DEPTH_W = 3;

    // Register indexes
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_PIXEL_DEPTH  = 2'd2;

    // Pixel depth codes
    localparam logic [DEPTH_W-1:0] DEPTH_1  = 3'd0;
    localparam logic [DEPTH_W-1:0] DEPTH_4  = 3'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_8  = 3'd2;
    localparam logic [DEPTH_W-1:0] DEPTH_24 = 3'd3;
    localparam logic [DEPTH_W-1:0] DEPTH_32 = 3'd4;

    // Input item kinds
    localparam logic KIND_PALETTE = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
        logic [DEPTH_W-1:0] pixel_depth;
    } cfg_t;

    // One queued command: a palette write, or one data byte with the
    // pixels it yields (count of them, first column, row).
    typedef struct packed {
        logic               is_pal_wr;
        logic [DEPTH_W-1:0] depth;
        logic [7:0]         data;    // data byte, or palette index on a write
        logic [23:0]        color;   // {red, green, blue}
        logic [11:0]        col;
        logic [11:0]        row;
        logic [3:0]         count;
        logic               done;    // last pixel of this command ends the image
    } cmd_t;

endpackage

`default_nettype wire

// ===== src/bpr_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Small register FIFO that decouples the byte classifier from pixel output.
// ----------------------------------------------------------------------------
`default_nettype none

module bpr_cmd_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire bpr_pkg::cmd_t cmd_in,
    output logic               full,
    input  wire logic          pop,
    output bpr_pkg::cmd_t      cmd_out,
    output logic               empty
);
    import bpr_pkg::*;

    cmd_t                 mem_reg [CMD_FIFO_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_PTR_W:0]   count_reg, count_next;

    assign full    = (count_reg == (CMD_PTR_W+1)'(CMD_FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign cmd_out = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop && !empty) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if ((push && !full) && !(pop && !empty)) begin
            count_next = count_reg + 1'b1;
        end else if (!(push && !full) && (pop && !empty)) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// ===== src/bpr_front.sv =====
// ----------------------------------------------------------------------------
// Byte classifier
// Tracks row, column and byte phase; turns palette writes and pixel-yielding bytes into commands.
// ----------------------------------------------------------------------------
`default_nettype none

module bpr_front #(
    parameter int MAX_WIDTH  = bpr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bpr_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire bpr_pkg::cfg_t cfg,
    input  wire logic      item_valid,
    output logic           item_ready,
    input  wire logic      item_kind,
    input  wire logic [7:0] item_byte,
    input  wire logic [7:0] item_pal_index,
    input  wire logic [23:0] item_pal_color,
    output logic           cmd_push,
    output bpr_pkg::cmd_t  cmd,
    input  wire logic      cmd_full
);
    import bpr_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int BW = $clog2(4 * MAX_WIDTH + 1);
    localparam int LW = CW + 6;

    logic [BW-1:0] byte_reg, byte_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] rows_reg, rows_next;
    logic [1:0]    phase_reg, phase_next;
    logic [7:0]    held_blue_reg, held_blue_next;
    logic [7:0]    held_green_reg, held_green_next;

    logic          accept;
    logic          active;
    logic [CW-1:0] w_eff, avail;
    logic [RW-1:0] h_eff;
    logic [LW-1:0] w_ext, bits, words;
    logic [BW-1:0] row_len, byte_inc;
    logic [3:0]    ppb, n_pix;

    assign item_ready = !cmd_full;
    assign accept     = item_valid && item_ready;

    always_comb begin
        // clamp width and height into the supported range
        if (cfg.image_width == '0) begin
            w_eff = CW'(1);
        end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(cfg.image_width);
        end
        if (cfg.image_height == '0) begin
            h_eff = RW'(1);
        end else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(cfg.image_height);
        end

        // padded row length in bytes: whole 32-bit words
        w_ext = LW'(w_eff);
        unique case (cfg.pixel_depth)
            DEPTH_1:  bits = w_ext;
            DEPTH_4:  bits = w_ext << 2;
            DEPTH_8:  bits = w_ext << 3;
            DEPTH_24: bits = (w_ext << 4) + (w_ext << 3);
            default:  bits = w_ext << 5;
        endcase
        words   = (bits + LW'(31)) >> 5;
        row_len = BW'({words, 2'b00});

        // pixels carried by this byte; a 24-bit group left at phase three
        // by a depth change still completes a pixel
        unique case (cfg.pixel_depth)
            DEPTH_1:  ppb = 4'd8;
            DEPTH_4:  ppb = 4'd2;
            DEPTH_8:  ppb = 4'd1;
            DEPTH_24: ppb = (phase_reg >= 2'd2) ? 4'd1 : 4'd0;
            DEPTH_32: ppb = (phase_reg == 2'd2) ? 4'd1 : 4'd0;
            default:  ppb = 4'd0;
        endcase
        avail = (col_reg < w_eff) ? (w_eff - col_reg) : '0;
        if (32'(avail) < 32'(ppb)) begin
            n_pix = 4'(avail);
        end else begin
            n_pix = ppb;
        end

        active = (cfg.pixel_depth <= DEPTH_32) && (rows_reg < h_eff);

        byte_next       = byte_reg;
        col_next        = col_reg;
        rows_next       = rows_reg;
        phase_next      = phase_reg;
        held_blue_next  = held_blue_reg;
        held_green_next = held_green_reg;
        byte_inc        = byte_reg + BW'(1);

        if (accept && item_kind == KIND_PIXEL && active) begin
            if (cfg.pixel_depth == DEPTH_24 || cfg.pixel_depth == DEPTH_32) begin
                if (phase_reg == 2'd0) begin
                    held_blue_next = item_byte;
                end else if (phase_reg == 2'd1) begin
                    held_green_next = item_byte;
                end
                if (cfg.pixel_depth == DEPTH_24 && phase_reg >= 2'd2) begin
                    phase_next = 2'd0;
                end else begin
                    phase_next = phase_reg + 2'd1;
                end
            end
            if (byte_inc >= row_len) begin
                byte_next  = '0;
                col_next   = '0;
                phase_next = 2'd0;
                rows_next  = rows_reg + RW'(1);
            end else begin
                byte_next = byte_inc;
                col_next  = col_reg + CW'(n_pix);
            end
        end

        cmd.is_pal_wr = (item_kind == KIND_PALETTE);
        cmd.depth     = cfg.pixel_depth;
        cmd.data      = (item_kind == KIND_PALETTE) ? item_pal_index : item_byte;
        cmd.color     = (item_kind == KIND_PALETTE) ? item_pal_color
                                                    : {item_byte, held_green_reg, held_blue_reg};
        cmd.col       = 12'(col_reg);
        cmd.row       = 12'(h_eff - RW'(1) - rows_reg);
        cmd.count     = n_pix;
        cmd.done      = (rows_reg == h_eff - RW'(1)) && (col_reg + CW'(n_pix) == w_eff);

        // drop bytes that yield no pixel; palette writes always go through
        cmd_push = accept && ((item_kind == KIND_PALETTE) || (active && n_pix != 4'd0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg       <= '0;
            col_reg        <= '0;
            rows_reg       <= '0;
            phase_reg      <= '0;
            held_blue_reg  <= '0;
            held_green_reg <= '0;
        end else begin
            byte_reg       <= byte_next;
            col_reg        <= col_next;
            rows_reg       <= rows_next;
            phase_reg      <= phase_next;
            held_blue_reg  <= held_blue_next;
            held_green_reg <= held_green_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/bpr_back.sv =====
// ----------------------------------------------------------------------------
// Pixel emitter
// Expands commands into pixels, looks up the palette, drives the output.
// ----------------------------------------------------------------------------
`default_nettype none

module bpr_back #(
    parameter int PALETTE_ENTRIES = bpr_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire bpr_pkg::cmd_t head,
    input  wire logic       head_valid,
    output logic            head_pop,
    output logic            pix_valid,
    input  wire logic       pix_ready,
    output logic [7:0]      pix_red,
    output logic [7:0]      pix_green,
    output logic [7:0]      pix_blue,
    output logic [11:0]     pix_column,
    output logic [11:0]     pix_row,
    output logic            pix_last,
    output logic            pix_done
);
    import bpr_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);

    logic [23:0] pal_mem [PALETTE_ENTRIES];
    logic [23:0] pal_rd_reg;

    logic [2:0]  k_reg, k_next;

    // lookup stage
    logic        s1_valid_reg;
    logic        s1_direct_reg;
    logic        s1_black_reg;
    logic [23:0] s1_color_reg;
    logic [11:0] s1_col_reg;
    logic [11:0] s1_row_reg;
    logic        s1_last_reg;
    logic        s1_done_reg;

    // output register
    logic        m_valid_reg;
    logic [23:0] m_color_reg;
    logic [11:0] m_col_reg;
    logic [11:0] m_row_reg;
    logic        m_last_reg;
    logic        m_done_reg;

    logic        advance, s1_en, issue, last_pix, direct, in_range, pal_we;
    logic [7:0]  idx;

    assign advance = !m_valid_reg || pix_ready;
    assign s1_en   = !s1_valid_reg || advance;

    always_comb begin
        // a palette write addresses its entry with the whole data byte
        if (head.is_pal_wr) begin
            idx = head.data;
        end else begin
            unique case (head.depth)
                DEPTH_1: idx = {7'd0, head.data[3'd7 - k_reg]};
                DEPTH_4: idx = k_reg[0] ? {4'd0, head.data[3:0]} : {4'd0, head.data[7:4]};
                default: idx = head.data;
            endcase
        end
        direct   = (head.depth == DEPTH_24) || (head.depth == DEPTH_32);
        in_range = (9'(idx) < 9'(PALETTE_ENTRIES));
        last_pix = ({1'b0, k_reg} + 4'd1 == head.count);
        issue    = head_valid && !head.is_pal_wr && s1_en;
        pal_we   = head_valid && head.is_pal_wr && in_range;
        head_pop = (head_valid && head.is_pal_wr) || (issue && last_pix);
        if (issue) begin
            k_next = last_pix ? 3'd0 : k_reg + 3'd1;
        end else begin
            k_next = k_reg;
        end
    end

    // palette store: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (pal_we) begin
            pal_mem[idx[AW-1:0]] <= head.color;
        end
        if (issue) begin
            pal_rd_reg <= pal_mem[idx[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg        <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            k_reg <= k_next;
            if (s1_en) begin
                s1_valid_reg <= issue;
            end
            if (advance) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            s1_direct_reg <= direct;
            s1_black_reg  <= !in_range;
            s1_color_reg  <= head.color;
            s1_col_reg    <= head.col + 12'(k_reg);
            s1_row_reg    <= head.row;
            s1_last_reg   <= last_pix;
            s1_done_reg   <= head.done && last_pix;
        end
        if (advance && s1_valid_reg) begin
            if (s1_direct_reg) begin
                m_color_reg <= s1_color_reg;
            end else if (s1_black_reg) begin
                m_color_reg <= '0;
            end else begin
                m_color_reg <= pal_rd_reg;
            end
            m_col_reg  <= s1_col_reg;
            m_row_reg  <= s1_row_reg;
            m_last_reg <= s1_last_reg;
            m_done_reg <= s1_done_reg;
        end
    end

    assign pix_valid  = m_valid_reg;
    assign pix_red    = m_color_reg[23:16];
    assign pix_green  = m_color_reg[15:8];
    assign pix_blue   = m_color_reg[7:0];
    assign pix_column = m_col_reg;
    assign pix_row    = m_row_reg;
    assign pix_last   = m_last_reg;
    assign pix_done   = m_done_reg;

endmodule

`default_nettype wire

// ===== src/bmp_pixel_row_decoder_core.sv =====
// ----------------------------------------------------------------------------
// BMP pixel row decoder core
// Decodes BMP pixel data bytes (1/4/8 bpp palette, 24/32 bpp BGR) into RGB
// pixels tagged with column and row.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  palette writes and pixel data bytes
//  m_*       out  m_tvalid/m_tready  decoded pixels, end of byte, end of image
//  cfg_*     in   cfg_we             image_width, image_height, pixel_depth
//
//  Input items enter at one per cycle while the command queue has room.
//  Output runs at one pixel per cycle while m_tready is high: a byte yields up
//  to 8 pixels at 1 bpp and 2 at 4 bpp, which sets the sustained rate there. A
//  byte's first pixel passes the queue, the palette read and the output register.
//  Reset is synchronous and active low; the palette store is not cleared.
//  A stalled m_tready backs up the queue, then drops s_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_pixel_row_decoder_core #(
    parameter int MAX_WIDTH       = bpr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT      = bpr_pkg::MAX_HEIGHT_DEF,
    parameter int PALETTE_ENTRIES = bpr_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_wdata,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // data_byte, palette_index, palette_red,
                                       // palette_green, palette_blue
    input  wire logic        s_tuser,  // kind
    // decoded pixels
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,  // red, green, blue, column, row
    output logic             m_tlast,  // last_of_run
    output logic             m_tuser   // image_done
);
    import bpr_pkg::*;

    cfg_t  cfg_reg;
    cmd_t  cmd_in, cmd_head;
    logic  cmd_push, cmd_full, cmd_pop, cmd_empty;

    logic [7:0]  pix_red, pix_green, pix_blue;
    logic [11:0] pix_column, pix_row;

    // hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width  <= DIM_W'(1);
            cfg_reg.image_height <= DIM_W'(1);
            cfg_reg.pixel_depth  <= DEPTH_32;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_wdata;
                CFG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_wdata;
                CFG_PIXEL_DEPTH:  cfg_reg.pixel_depth  <= cfg_wdata[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    // front: classify bytes, advance row state, queue commands
    // palette color goes down as {red, green, blue}
    bpr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .item_valid     (s_tvalid),
        .item_ready     (s_tready),
        .item_kind      (s_tuser),
        .item_byte      (s_tdata[7:0]),
        .item_pal_index (s_tdata[15:8]),
        .item_pal_color ({s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]}),
        .cmd_push       (cmd_push),
        .cmd            (cmd_in),
        .cmd_full       (cmd_full)
    );

    // queue: lets the front keep taking bytes while pixels drain
    bpr_cmd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (cmd_push),
        .cmd_in  (cmd_in),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .cmd_out (cmd_head),
        .empty   (cmd_empty)
    );

    // back: expand into pixels, palette lookup, output register
    bpr_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (cmd_head),
        .head_valid (!cmd_empty),
        .head_pop   (cmd_pop),
        .pix_valid  (m_tvalid),
        .pix_ready  (m_tready),
        .pix_red    (pix_red),
        .pix_green  (pix_green),
        .pix_blue   (pix_blue),
        .pix_column (pix_column),
        .pix_row    (pix_row),
        .pix_last   (m_tlast),
        .pix_done   (m_tuser)
    );

    assign m_tdata = {pix_row, pix_column, pix_blue, pix_green, pix_red};

endmodule

`default_nettype wire
